// ===== hw/rtl/psd_pkg.sv =====
package psd_pkg;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int KIND_W   = 2;
   localparam int DEV_W    = 32;
   localparam int STATUS_W = 2;

   // default parameter values
   localparam int MAX_ITEMS_DEF   = 4096;
   localparam int SAMPLE_BITS_DEF = 24;

   // accumulator and work widths
   localparam int COUNT_W = 13;                  // holds up to 4096
   localparam int SUM_W   = 36;                  // signed running sum
   localparam int MAG_W   = 36;                  // magnitude of the sum
   localparam int SQ_W    = 2 * SAMPLE_W - 1;    // one square
   localparam int SQSUM_W = 60;                  // running sum of squares
   localparam int PROD_W  = 72;                  // n*S2 - S1^2
   localparam int ROOT_W  = 44;                  // root of (PROD << 16)
   localparam int REM_W   = ROOT_W + 3;          // root remainder
   localparam int STEP_W  = 6;

   // iteration counts of the sequential units
   localparam int MUL_N_STEPS = COUNT_W;
   localparam int MUL_S_STEPS = MAG_W;
   localparam int ROOT_STEPS  = ROOT_W;
   localparam int DIV_STEPS   = ROOT_W;

   // kind codes
   localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEXT   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NULL   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_LONG  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_PREP_N,
      ST_MUL_N,
      ST_PREP_S,
      ST_MUL_S,
      ST_PREP_R,
      ST_ROOT,
      ST_DIV,
      ST_DONE
   } psd_state_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD_N,
      OP_MUL_N,
      OP_LOAD_S,
      OP_MUL_S,
      OP_LOAD_R,
      OP_ROOT,
      OP_DIV
   } psd_op_type;

   // controller to datapath
   typedef struct packed {
      logic       take;
      psd_op_type op;
      logic       load_out;
      logic       clear;
   } psd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ends;
      logic need_root;
   } psd_sts_type;

endpackage

// ===== hw/rtl/psd_ctrl.sv =====
module psd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  psd_pkg::psd_sts_type sts,
   output psd_pkg::psd_cmd_type cmd
);
   import psd_pkg::*;

   psd_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              take;
   logic              step_last;
   logic              out_free;

   assign take      = req_valid && (state_ff == ST_IDLE);
   assign step_last = (step_ff == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && sts.ends) begin
               state_in = sts.need_root ? ST_SETTLE : ST_DONE;
            end
         end
         ST_SETTLE: state_in = ST_PREP_N;
         ST_PREP_N: state_in = ST_MUL_N;
         ST_MUL_N: begin
            if (step_last) state_in = ST_PREP_S;
         end
         ST_PREP_S: state_in = ST_MUL_S;
         ST_MUL_S: begin
            if (step_last) state_in = ST_PREP_R;
         end
         ST_PREP_R: state_in = ST_ROOT;
         ST_ROOT: begin
            if (step_last) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands and step counter
   always_comb begin
      cmd.take     = take;
      cmd.op       = OP_HOLD;
      cmd.load_out = 1'b0;
      cmd.clear    = 1'b0;
      step_in      = step_ff;
      case (state_ff)
         ST_PREP_N: begin
            cmd.op  = OP_LOAD_N;
            step_in = STEP_W'(MUL_N_STEPS - 1);
         end
         ST_MUL_N: begin
            cmd.op  = OP_MUL_N;
            step_in = step_ff - 1'b1;
         end
         ST_PREP_S: begin
            cmd.op  = OP_LOAD_S;
            step_in = STEP_W'(MUL_S_STEPS - 1);
         end
         ST_MUL_S: begin
            cmd.op  = OP_MUL_S;
            step_in = step_ff - 1'b1;
         end
         ST_PREP_R: begin
            cmd.op  = OP_LOAD_R;
            step_in = STEP_W'(ROOT_STEPS - 1);
         end
         ST_ROOT: begin
            cmd.op  = OP_ROOT;
            step_in = step_last ? STEP_W'(DIV_STEPS - 1) : step_ff - 1'b1;
         end
         ST_DIV: begin
            cmd.op  = OP_DIV;
            step_in = step_ff - 1'b1;
         end
         ST_DONE: begin
            cmd.load_out = out_free;
            cmd.clear    = out_free;
         end
         default: cmd.op = OP_HOLD;
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/psd_dp.sv =====
module psd_dp #(
   parameter int MAX_ITEMS   = psd_pkg::MAX_ITEMS_DEF,
   parameter int SAMPLE_BITS = psd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [psd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic        [psd_pkg::KIND_W-1:0]   req_kind,
   input  logic                                req_last,
   input  psd_pkg::psd_cmd_type                cmd,
   output psd_pkg::psd_sts_type                sts,
   output logic        [psd_pkg::DEV_W-1:0]    rsp_deviation,
   output logic        [psd_pkg::STATUS_W-1:0] rsp_status
);
   import psd_pkg::*;

   localparam int EXT_SHIFT = SAMPLE_W - SAMPLE_BITS;

   // list accumulators
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQSUM_W-1:0]        sqsum_ff, sqsum_in;
   logic                      poisoned_ff, poisoned_in;
   logic                      overflowed_ff, overflowed_in;
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic                      sq_pend_ff, sq_pend_in;
   logic [STATUS_W-1:0]       status_ff, status_in;

   // work registers of the final computation
   logic [PROD_W-1:0]         mcand_ff, mcand_in;
   logic [MAG_W-1:0]          mplier_ff, mplier_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [COUNT_W-1:0]        drem_ff, drem_in;
   logic [DEV_W-1:0]          dev_ff, dev_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;

   logic signed [SAMPLE_W-1:0]   s_shl;
   logic signed [SAMPLE_W-1:0]   s_val;
   logic signed [2*SAMPLE_W-1:0] sq_full;
   logic                         is_number;
   logic                         full;
   logic                         grow;
   logic                         poison_nx;
   logic                         overflow_nx;
   logic [COUNT_W-1:0]           count_nx;
   logic [STATUS_W-1:0]          status_nx;
   logic [MAG_W-1:0]             mag;
   logic [REM_W-1:0]             rem_t;
   logic [REM_W-1:0]             trial;
   logic [COUNT_W:0]             drem_t;
   logic [COUNT_W:0]             divisor;

   // sign-extend the sample from SAMPLE_BITS
   assign s_shl   = req_sample <<< EXT_SHIFT;
   assign s_val   = s_shl >>> EXT_SHIFT;
   assign sq_full = s_val * s_val;

   // effect of the offered request on the list state
   assign is_number   = (req_kind == KIND_NUMBER);
   assign full        = (count_ff >= COUNT_W'(MAX_ITEMS));
   assign grow        = is_number && !full;
   assign poison_nx   = poisoned_ff || (req_kind == KIND_TEXT);
   assign overflow_nx = overflowed_ff || (is_number && full);
   assign count_nx    = count_ff + {{(COUNT_W-1){1'b0}}, grow};

   always_comb begin
      if (req_kind == KIND_NULL) begin
         status_nx = STAT_NULL;
      end else if (req_kind == KIND_EMPTY) begin
         status_nx = STAT_EMPTY;
      end else if (poison_nx) begin
         status_nx = STAT_NULL;
      end else if (overflow_nx) begin
         status_nx = STAT_LONG;
      end else if (count_nx == '0) begin
         status_nx = STAT_EMPTY;
      end else begin
         status_nx = STAT_OK;
      end
   end

   assign sts.ends      = req_last || (req_kind == KIND_NULL) || (req_kind == KIND_EMPTY);
   assign sts.need_root = sts.ends && (status_nx == STAT_OK);

   // accumulation: sum added at acceptance, square added in the cycle after
   always_comb begin
      count_in      = count_ff;
      sum_in        = sum_ff;
      sqsum_in      = sqsum_ff;
      poisoned_in   = poisoned_ff;
      overflowed_in = overflowed_ff;
      sq_in         = sq_ff;
      sq_pend_in    = 1'b0;
      status_in     = status_ff;
      if (sq_pend_ff) begin
         sqsum_in = sqsum_ff + {{(SQSUM_W-SQ_W){1'b0}}, sq_ff};
      end
      if (cmd.take) begin
         count_in      = count_nx;
         poisoned_in   = poison_nx;
         overflowed_in = overflow_nx;
         if (sts.ends) status_in = status_nx;
         if (grow) begin
            sum_in     = sum_ff + {{(SUM_W-SAMPLE_W){s_val[SAMPLE_W-1]}}, s_val};
            sq_in      = sq_full[SQ_W-1:0];
            sq_pend_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         count_in      = '0;
         sum_in        = '0;
         sqsum_in      = '0;
         poisoned_in   = 1'b0;
         overflowed_in = 1'b0;
         sq_pend_in    = 1'b0;
      end
   end

   assign mag = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);

   // root and divide step terms
   assign rem_t   = {rem_ff[REM_W-3:0], prod_ff[PROD_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign drem_t  = {drem_ff, root_ff[ROOT_W-1]};
   assign divisor = {1'b0, count_ff};

   // shared sequential units: shift-add multiply (shift-subtract for the square), digit root, restoring divide
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      drem_in   = drem_ff;
      case (cmd.op)
         OP_LOAD_N: begin
            mcand_in  = {{(PROD_W-SQSUM_W){1'b0}}, sqsum_ff};
            mplier_in = {{(MAG_W-COUNT_W){1'b0}}, count_ff};
            prod_in   = '0;
         end
         OP_MUL_N: begin
            if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
         end
         OP_LOAD_S: begin
            mcand_in  = {{(PROD_W-MAG_W){1'b0}}, mag};
            mplier_in = mag;
         end
         OP_MUL_S: begin
            if (mplier_ff[0]) prod_in = prod_ff - mcand_ff;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
         end
         OP_LOAD_R: begin
            rem_in  = '0;
            root_in = '0;
            drem_in = '0;
         end
         OP_ROOT: begin
            prod_in = prod_ff << 2;
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_DIV: begin
            if (drem_t >= divisor) begin
               drem_in = COUNT_W'(drem_t - divisor);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               drem_in = drem_t[COUNT_W-1:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         default: prod_in = prod_ff;
      endcase
   end

   // result register
   always_comb begin
      dev_in        = dev_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.load_out) begin
         dev_in        = (status_ff == STAT_OK) ? root_ff[DEV_W-1:0] : '0;
         rsp_status_in = status_ff;
      end
   end

   assign rsp_deviation = dev_ff;
   assign rsp_status    = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sum_ff        <= '0;
         sqsum_ff      <= '0;
         poisoned_ff   <= 1'b0;
         overflowed_ff <= 1'b0;
         sq_pend_ff    <= 1'b0;
      end else begin
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         sqsum_ff      <= sqsum_in;
         poisoned_ff   <= poisoned_in;
         overflowed_ff <= overflowed_in;
         sq_pend_ff    <= sq_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff         <= sq_in;
      status_ff     <= status_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      drem_ff       <= drem_in;
      dev_ff        <= dev_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== hw/rtl/population_std_deviation.sv =====
// Sequence: a request that ends a list with a numeric result is answered after a 13-step
//   multiply by n, a 36-step square of the sum, a 44-step root and a 44-step divide, plus
//   setup states; null, empty and too-long endings go straight to the response register.
// Throughput: one request per cycle within a list; the block takes no request while a
//   list's end is being computed. The response register lets a new list start early.
// Reset: synchronous, active high; clears the running count, sums, flags and FSM.
module population_std_deviation #(
   parameter int MAX_ITEMS   = psd_pkg::MAX_ITEMS_DEF,
   parameter int SAMPLE_BITS = psd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [psd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic        [psd_pkg::KIND_W-1:0]   req_kind,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [psd_pkg::DEV_W-1:0]    rsp_deviation,
   output logic        [psd_pkg::STATUS_W-1:0] rsp_status
);
   import psd_pkg::*;

   psd_cmd_type cmd;
   psd_sts_type sts;

   // sequencing
   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // accumulators and arithmetic
   psd_dp #(
      .MAX_ITEMS   (MAX_ITEMS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_sample    (req_sample),
      .req_kind      (req_kind),
      .req_last      (req_last),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_deviation (rsp_deviation),
      .rsp_status    (rsp_status)
   );

endmodule
